// ===== hdl/wbps_pkg.sv =====
// Shared types, constants and codes of the wildcard byte pattern scanner.
package wbps_pkg;

   localparam int PATTERN_MAX_DEF = 64;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W         = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX      = {COUNT_W{1'b1}};
   localparam logic [7:0]         WILDCARD_RESET = 8'h2A;
   localparam logic [6:0]         LENGTH_RESET   = 7'd1;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_SCAN = 1'b1;

   localparam logic [1:0] CSR_PATTERN_LENGTH = 2'd0;
   localparam logic [1:0] CSR_WILDCARD_VALUE = 2'd1;
   localparam logic [1:0] CSR_FIND_ALL       = 2'd2;
   localparam logic [1:0] CSR_REGION_BASE    = 2'd3;

   typedef struct packed {
      logic       is_scan;
      logic [5:0] entry_index;
      logic [7:0] byte_value;
      logic       last_byte;
   } op_type;

   typedef struct packed {
      logic [6:0]  pattern_length;
      logic [7:0]  wildcard_value;
      logic        find_all;
      logic [63:0] region_base;
   } cfg_type;

endpackage

// ===== hdl/wbps_front.sv =====
// Input side: takes request words, classifies them and queues them for the back end.
module wbps_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [15:0]     req_tdata,   // entry_index [5:0], byte_value [13:6], zero fill
   input  logic            req_tuser,   // func
   input  logic            req_tlast,   // last_byte
   output logic            op_valid,
   input  logic            op_ready,
   output wbps_pkg::op_type op
);
   import wbps_pkg::*;

   op_type                 queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   fill_ff, fill_in;
   logic                   push, pop;
   op_type                 decoded;

   always_comb begin
      decoded.is_scan     = (req_tuser == FUNC_SCAN);
      decoded.entry_index = req_tdata[5:0];
      decoded.byte_value  = req_tdata[13:6];
      decoded.last_byte   = (req_tuser == FUNC_SCAN) && req_tlast;
   end

   assign req_tready = (fill_ff != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign op_valid   = (fill_ff != '0);
   assign op         = queue_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = op_valid && op_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ===== hdl/wbps_back.sv =====
// Execution side: pattern store, byte window, counter, window compare and result register.
module wbps_back #(
   parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  wbps_pkg::cfg_type cfg,
   input  logic              op_valid,
   output logic              op_ready,
   input  wbps_pkg::op_type  op,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [63:0]       rsp_tdata,
   output logic              rsp_tuser,
   output logic              rsp_tlast
);
   import wbps_pkg::*;

   localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int LEN_W = $clog2(PATTERN_MAX + 1);

   logic [7:0]         pattern_ff [PATTERN_MAX];
   logic [7:0]         window_ff [PATTERN_MAX];
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_check_ff, s1_check_in;
   logic               s1_last_ff, s1_last_in;
   logic [COUNT_W-1:0] s1_offset_ff, s1_offset_in;
   logic               found_ff, found_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_addr_ff, rsp_addr_in;
   logic               rsp_found_ff, rsp_found_in;
   logic               rsp_done_ff, rsp_done_in;

   logic [31:0]        len_wide;
   logic [LEN_W-1:0]   act_len;
   logic [31:0]        wr_idx_wide;
   logic               pop, pop_scan, pop_load;
   logic               out_free, retire, s1_free;
   logic [COUNT_W-1:0] count_next;
   logic [PATTERN_MAX-1:0] lane_ok;
   logic               hit, emit, rep_found;

   always_comb begin
      len_wide = 32'(cfg.pattern_length);
      if (len_wide == 32'd0) begin
         len_wide = 32'd1;
      end else if (len_wide > 32'(PATTERN_MAX)) begin
         len_wide = 32'(PATTERN_MAX);
      end
      act_len = len_wide[LEN_W-1:0];
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign retire   = s1_valid_ff && (out_free || !emit);
   assign s1_free  = !s1_valid_ff || retire;
   assign op_ready = s1_free;
   assign pop      = op_valid && s1_free;
   assign pop_scan = pop && op.is_scan;
   assign pop_load = pop && !op.is_scan;

   assign wr_idx_wide = 32'(op.entry_index);

   always_ff @(posedge clock) begin
      if (pop_load && (wr_idx_wide < 32'(PATTERN_MAX))) begin
         pattern_ff[wr_idx_wide[IDX_W-1:0]] <= op.byte_value;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_scan) begin
         window_ff[0] <= op.byte_value;
         for (int i = 1; i < PATTERN_MAX; i++) begin
            window_ff[i] <= window_ff[i-1];
         end
      end
   end

   // Stage one: count the byte and decide whether this position is checked.
   always_comb begin
      count_next   = count_ff + 1'b1;
      count_in     = count_ff;
      s1_valid_in  = s1_valid_ff && !retire;
      s1_check_in  = s1_check_ff;
      s1_last_in   = s1_last_ff;
      s1_offset_in = s1_offset_ff;
      if (pop_scan) begin
         s1_valid_in  = 1'b1;
         s1_last_in   = op.last_byte;
         s1_check_in  = (count_ff != COUNT_MAX) && (count_next >= COUNT_W'(act_len));
         s1_offset_in = count_next - COUNT_W'(act_len);
         if (op.last_byte) begin
            count_in = '0;
         end else if (count_ff != COUNT_MAX) begin
            count_in = count_next;
         end
      end
   end

   // Stage two: compare the window with the pattern and form the result.
   always_comb begin
      logic [31:0] sel_wide;
      for (int j = 0; j < PATTERN_MAX; j++) begin
         sel_wide   = 32'(act_len) - 32'd1 - 32'(j);
         lane_ok[j] = (32'(j) >= 32'(act_len))
                   || (pattern_ff[j] == cfg.wildcard_value)
                   || (pattern_ff[j] == window_ff[sel_wide[IDX_W-1:0]]);
      end
      hit = s1_check_ff && (&lane_ok);
   end

   always_comb begin
      rep_found = hit && (cfg.find_all || !found_ff);
      if (cfg.find_all) begin
         emit = hit || s1_last_ff;
      end else begin
         emit = !found_ff && (hit || s1_last_ff);
      end
      found_in = found_ff;
      if (retire) begin
         if (s1_last_ff) begin
            found_in = 1'b0;
         end else if (!cfg.find_all && hit) begin
            found_in = 1'b1;
         end
      end
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_addr_in  = rsp_addr_ff;
      rsp_found_in = rsp_found_ff;
      rsp_done_in  = rsp_done_ff;
      if (retire && emit) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = rep_found;
         rsp_addr_in  = rep_found ? cfg.region_base + 64'(s1_offset_ff) : 64'd0;
         rsp_done_in  = s1_last_ff || !cfg.find_all;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         s1_valid_ff  <= s1_valid_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_check_ff  <= s1_check_in;
      s1_last_ff   <= s1_last_in;
      s1_offset_ff <= s1_offset_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_found_ff <= rsp_found_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tlast  = rsp_done_ff;

endmodule

// ===== hdl/wildcard_byte_pattern_scan_top.sv =====
// Top level of the wildcard byte pattern scanner: register file and the two halves.
//
// Request words carry either a pattern byte to store (tuser low, stored at
// entry_index) or a data byte to scan (tuser high, tlast ending the region).
// Each scanned byte is shifted into a window that is compared in parallel
// with the stored pattern; a pattern byte equal to the wildcard matches any
// data byte. Find-first mode reports the first match with tlast set and keeps
// the rest of the region silent; find-all mode reports every match. A region
// with no report ends in a word with tuser low and tlast set. Result tuser is
// the found flag and tdata is region_base plus the offset of the match start.
// One request word is taken every cycle while the queue has room; a result
// word passes from the queue through the window compare stage into the output
// register. A stalled receiver holds the output register; the four-word queue
// and the compare stage keep taking words until they are full. Reset empties
// the queue, clears the counter and restores the register defaults; pattern
// bytes hold no value until written.
module wildcard_byte_pattern_scan_top #(
   parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // entry_index [5:0], byte_value [13:6], zero fill
   input  logic        req_tuser,   // func
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // match_address [63:0]
   output logic        rsp_tuser,   // found
   output logic        rsp_tlast,   // region_done
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import wbps_pkg::*;

   cfg_type cfg_ff, cfg_in;
   op_type  op;
   logic    op_valid, op_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PATTERN_LENGTH: cfg_in.pattern_length = csr_wdata[6:0];
            CSR_WILDCARD_VALUE: cfg_in.wildcard_value = csr_wdata[7:0];
            CSR_FIND_ALL:       cfg_in.find_all       = csr_wdata[0];
            CSR_REGION_BASE:    cfg_in.region_base    = csr_wdata;
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_length <= LENGTH_RESET;
         cfg_ff.wildcard_value <= WILDCARD_RESET;
         cfg_ff.find_all       <= 1'b0;
         cfg_ff.region_base    <= 64'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wbps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .op_valid   (op_valid),
      .op_ready   (op_ready),
      .op         (op)
   );

   wbps_back #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .op_valid   (op_valid),
      .op_ready   (op_ready),
      .op         (op),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== hdl/wbps_checker.sv =====
// Port-level assertions on the result channel, bound to the scanner top level.
module wbps_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // A word that is not taken stays offered unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // A word without a match carries a zero address.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 64'd0)
      else $error("not-found word with non-zero address");

   // A word without a match is only ever the end of a region.
   a_miss_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("not-found word outside region end");

   // Reset leaves nothing on offer.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word offered straight after reset");

endmodule

bind wildcard_byte_pattern_scan_top wbps_checker u_checker (.*);

// ===== tb/tb_wildcard_byte_pattern_scan_top.sv =====
// Self-checking testbench for the wildcard byte pattern scanner: directed table, then random phases.
module tb_wildcard_byte_pattern_scan_top;
   timeunit 1ns;
   timeprecision 1ps;

   import wbps_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 12;
   localparam int RANDOM_WORDS   = 400;
   localparam int QUIET_FROM     = 320;

   typedef struct packed {
      logic        found;
      logic [63:0] addr;
      logic        done;
   } scan_result_type;

   typedef enum logic {ROW_WORD, ROW_REG} row_kind_type;
   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} row_check_type;

   typedef struct packed {
      row_kind_type    kind;
      logic [1:0]      reg_idx;
      logic [63:0]     reg_data;
      logic            func;
      logic [5:0]      entry;
      logic [7:0]      value;
      logic            last;
      row_check_type   check;
      scan_result_type want;
   } stim_row_type;

   localparam scan_result_type NO_RESULT = '{1'b0, 64'd0, 1'b0};
   localparam logic [63:0]     ALL_ONES  = {64{1'b1}};

   localparam stim_row_type DIRECTED [0:24] = '{
      '{ROW_WORD, CSR_PATTERN_LENGTH, 64'd0, FUNC_LOAD, 6'd0, 8'h2A, 1'b1, CHK_MODEL, NO_RESULT},
      '{ROW_WORD, CSR_PATTERN_LENGTH, 64'd0, FUNC_SCAN, 6'h3F, 8'h00, 1'b0, CHK_TYPED,
        '{1'b1, 64'd0, 1'b1}},
      '{ROW_WORD, CSR_PATTERN_LENGTH, 64'd0, FUNC_SCAN, 6'd0, 8'hFF, 1'b0, CHK_MODEL, NO_RESULT},
      '{ROW_WORD, CSR_PATTERN_LENGTH, 64'd0, FUNC_SCAN, 6'd0, 8'h55, 1'b1, CHK_MODEL, NO_RESULT},
      '{ROW_REG, CSR_FIND_ALL, 64'd1, FUNC_LOAD, 6'd0, 8'd0, 1'b0, CHK_NONE, NO_RESULT},
      '{ROW_WORD, CSR_PATTERN_LENGTH, 64'd0, FUNC_SCAN, 6'd0, 8'hFF, 1'b0, CHK_TYPED,
        '{1'b1, 64'd0, 1'b0}},
      '{ROW_WORD, CSR_PATTERN_LENGTH, 64'd0, FUNC_SCAN, 6'd0, 8'h00, 1'b1, CHK_TYPED,
        '{1'b1, 64'd1, 1'b1}},
      '{ROW_REG, CSR_WILDCARD_VALUE, 64'd0, FUNC_LOAD, 6'd0, 8'd0, 1'b0, CHK_NONE, NO_RESULT},
      '{ROW_WORD, CSR_PATTERN_LENGTH, 64'd0, FUNC_SCAN, 6'd0, 8'h2B, 1'b1, CHK_TYPED,
        '{1'b0, 64'd0, 1'b1}},
      '{ROW_WORD, CSR_PATTERN_LENGTH, 64'd0, FUNC_SCAN, 6'd0, 8'h2A, 1'b1, CHK_TYPED,
        '{1'b1, 64'd0, 1'b1}},
      '{ROW_REG, CSR_REGION_BASE, ALL_ONES, FUNC_LOAD, 6'd0, 8'd0, 1'b0, CHK_NONE, NO_RESULT},
      '{ROW_WORD, CSR_PATTERN_LENGTH, 64'd0, FUNC_LOAD, 6'd63, 8'hFF, 1'b0, CHK_MODEL, NO_RESULT},
      '{ROW_WORD, CSR_PATTERN_LENGTH, 64'd0, FUNC_LOAD, 6'd1, 8'h00, 1'b1, CHK_MODEL, NO_RESULT},
      '{ROW_REG, CSR_PATTERN_LENGTH, 64'd0, FUNC_LOAD, 6'd0, 8'd0, 1'b0, CHK_NONE, NO_RESULT},
      '{ROW_WORD, CSR_PATTERN_LENGTH, 64'd0, FUNC_SCAN, 6'd0, 8'h2A, 1'b0, CHK_TYPED,
        '{1'b1, ALL_ONES, 1'b0}},
      '{ROW_WORD, CSR_PATTERN_LENGTH, 64'd0, FUNC_SCAN, 6'd0, 8'h2A, 1'b1, CHK_TYPED,
        '{1'b1, 64'd0, 1'b1}},
      '{ROW_REG, CSR_PATTERN_LENGTH, 64'd2, FUNC_LOAD, 6'd0, 8'd0, 1'b0, CHK_NONE, NO_RESULT},
      '{ROW_WORD, CSR_PATTERN_LENGTH, 64'd0, FUNC_SCAN, 6'd0, 8'h2A, 1'b0, CHK_MODEL, NO_RESULT},
      '{ROW_WORD, CSR_PATTERN_LENGTH, 64'd0, FUNC_SCAN, 6'd0, 8'h07, 1'b0, CHK_MODEL, NO_RESULT},
      '{ROW_WORD, CSR_PATTERN_LENGTH, 64'd0, FUNC_SCAN, 6'd0, 8'h2A, 1'b1, CHK_MODEL, NO_RESULT},
      '{ROW_REG, CSR_FIND_ALL, 64'd0, FUNC_LOAD, 6'd0, 8'd0, 1'b0, CHK_NONE, NO_RESULT},
      '{ROW_REG, CSR_REGION_BASE, 64'h8000_0000_0000_0000, FUNC_LOAD, 6'd0, 8'd0, 1'b0,
        CHK_NONE, NO_RESULT},
      '{ROW_REG, CSR_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FF82, FUNC_LOAD, 6'd0, 8'd0, 1'b0,
        CHK_NONE, NO_RESULT},
      '{ROW_WORD, CSR_PATTERN_LENGTH, 64'd0, FUNC_SCAN, 6'd0, 8'h2A, 1'b0, CHK_MODEL, NO_RESULT},
      '{ROW_WORD, CSR_PATTERN_LENGTH, 64'd0, FUNC_SCAN, 6'd0, 8'h2A, 1'b1, CHK_MODEL, NO_RESULT}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // entry_index [5:0], byte_value [13:6], zero fill
   logic        req_tuser  = 1'b0; // func
   logic        req_tlast  = 1'b0; // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // match_address [63:0]
   logic        rsp_tuser;         // found
   logic        rsp_tlast;         // region_done
   logic        csr_wr_en  = 1'b0;
   logic [1:0]  csr_index  = '0;
   logic [63:0] csr_wdata  = '0;

   wildcard_byte_pattern_scan_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Scanner state as seen from outside.
   logic [6:0]   cfg_len  = LENGTH_RESET;
   logic [7:0]   cfg_wild = WILDCARD_RESET;
   logic         cfg_all  = 1'b0;
   logic [63:0]  cfg_base = '0;
   logic [7:0]   pat_store [0:PATTERN_MAX_DEF-1] = '{default: 8'h00};
   logic [7:0]   win       [0:PATTERN_MAX_DEF-1] = '{default: 8'h00};
   logic [31:0]  seen      = '0;
   bit           got_first = 1'b0;

   scan_result_type pending_results [$];
   scan_result_type want_res;
   int unsigned  fail_count  = 0;
   int unsigned  word_count  = 0;
   int unsigned  idle_cycles = 0;
   int unsigned  stall_hold  = 0;
   bit           gaps_on     = 1'b1;
   bit           stalls_on   = 1'b1;

   function automatic int unsigned eff_length(input logic [6:0] raw);
      if (raw == 0) return 1;
      if (raw > PATTERN_MAX_DEF) return PATTERN_MAX_DEF;
      return 32'(raw);
   endfunction

   function automatic void clear_region();
      win       = '{default: 8'h00};
      seen      = '0;
      got_first = 1'b0;
   endfunction

   function automatic bit scan_predict(input logic func, input logic [5:0] entry,
                                       input logic [7:0] value, input logic last,
                                       output scan_result_type res);
      int unsigned len;
      bit          hit;
      logic [63:0] addr;
      hit  = 1'b0;
      addr = '0;
      res  = NO_RESULT;
      if (func == FUNC_LOAD) begin
         pat_store[entry] = value;
         return 1'b0;
      end
      for (int k = PATTERN_MAX_DEF - 1; k > 0; k--) win[k] = win[k-1];
      win[0] = value;
      len = eff_length(cfg_len);
      if (seen != COUNT_MAX) begin
         seen++;
         if (seen >= len) begin
            hit = 1'b1;
            for (int j = 0; j < len; j++) begin
               if (pat_store[j] != cfg_wild && pat_store[j] != win[len-1-j]) hit = 1'b0;
            end
            if (hit) addr = cfg_base + 64'(seen - len);
         end
      end
      if (!cfg_all) begin
         if (got_first) begin
            if (last) clear_region();
            return 1'b0;
         end
         if (hit) begin
            res = '{1'b1, addr, 1'b1};
            if (last) clear_region();
            else got_first = 1'b1;
            return 1'b1;
         end
      end else if (hit) begin
         res = '{1'b1, addr, last};
         if (last) clear_region();
         return 1'b1;
      end
      if (last) begin
         res = '{1'b0, 64'd0, 1'b1};
         clear_region();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [7:0] pick_byte();
      if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 3));
      return 8'($urandom);
   endfunction

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [63:0] data);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_PATTERN_LENGTH: cfg_len  = data[6:0];
         CSR_WILDCARD_VALUE: cfg_wild = data[7:0];
         CSR_FIND_ALL:       cfg_all  = data[0];
         CSR_REGION_BASE:    cfg_base = data;
         default: ;
      endcase
   endtask

   task automatic send_word(input logic func, input logic [5:0] entry, input logic [7:0] value,
                            input logic last, input row_check_type check,
                            input scan_result_type typed);
      scan_result_type model_res;
      bit              has_res;
      if (gaps_on && word_count < QUIET_FROM && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tlast  <= last;
      req_tdata  <= {2'b00, value, entry};
      do @(posedge clock); while (!req_tready);
      has_res = scan_predict(func, entry, value, last, model_res);
      if (check == CHK_MODEL && has_res) pending_results.push_back(model_res);
      else if (check == CHK_TYPED) pending_results.push_back(typed);
      word_count++;
   endtask

   always @(posedge clock) begin
      if (stall_hold != 0) begin
         rsp_tready <= 1'b0;
         stall_hold <= stall_hold - 1;
      end else if (stalls_on && word_count < QUIET_FROM && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_hold <= $urandom_range(0, 12);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result word: found %0d, match_address %h, region_done %0d",
                   rsp_tuser, rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            want_res = pending_results.pop_front();
            if (rsp_tuser !== want_res.found) begin
               $error("found: expected %0d, got %0d", want_res.found, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata !== want_res.addr) begin
               $error("match_address: expected %h, got %h", want_res.addr, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== want_res.done) begin
               $error("region_done: expected %0d, got %0d", want_res.done, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int unsigned phase;
      int unsigned eff;
      int unsigned n;
      int unsigned off;
      int unsigned regions;
      logic [6:0]  raw_len;
      logic [7:0]  wild;
      logic [63:0] data;
      logic [7:0]  region_bytes [$];
      bit          ends;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[r]) begin
         if (DIRECTED[r].kind == ROW_REG)
            csr_write(DIRECTED[r].reg_idx, DIRECTED[r].reg_data);
         else
            send_word(DIRECTED[r].func, DIRECTED[r].entry, DIRECTED[r].value,
                      DIRECTED[r].last, DIRECTED[r].check, DIRECTED[r].want);
      end

      phase      = 0;
      word_count = 0;
      while (word_count < RANDOM_WORDS) begin
         gaps_on   = (word_count < QUIET_FROM) && (phase % 4 != 3);
         stalls_on = gaps_on;

         case ($urandom_range(0, 15)) inside
            0:       raw_len = 7'd0;
            1:       raw_len = 7'd64;
            2:       raw_len = 7'($urandom_range(65, 127));
            [3:5]:   raw_len = 7'($urandom_range(9, 20));
            default: raw_len = 7'($urandom_range(1, 8));
         endcase
         if (phase == 0) raw_len = 7'd127;
         if (phase == 1) raw_len = 7'd0;
         case ($urandom_range(0, 3))
            0:       wild = WILDCARD_RESET;
            1:       wild = 8'h00;
            2:       wild = 8'hFF;
            default: wild = 8'($urandom);
         endcase

         data      = {$urandom, $urandom};
         data[6:0] = raw_len;
         csr_write(CSR_PATTERN_LENGTH, data);
         data      = {$urandom, $urandom};
         data[7:0] = wild;
         csr_write(CSR_WILDCARD_VALUE, data);
         data      = {$urandom, $urandom};
         csr_write(CSR_FIND_ALL, data);
         case ($urandom_range(0, 3))
            0:       data = '0;
            1:       data = ALL_ONES;
            2:       data = {$urandom, $urandom};
            default: data = {32'hFFFF_FFFF, $urandom};
         endcase
         csr_write(CSR_REGION_BASE, data);

         eff = eff_length(raw_len);
         for (int j = 0; j < eff; j++)
            send_word(FUNC_LOAD, 6'(j), ($urandom_range(0, 3) == 0) ? wild : pick_byte(),
                      1'($urandom), CHK_MODEL, NO_RESULT);

         regions = $urandom_range(2, 5);
         for (int r = 0; r < regions && word_count < RANDOM_WORDS; r++) begin
            n = $urandom_range(1, eff + 12);
            region_bytes.delete();
            for (int b = 0; b < n; b++) region_bytes.push_back(pick_byte());
            if (n >= eff && $urandom_range(0, 1) == 0) begin
               off = $urandom_range(0, n - eff);
               for (int j = 0; j < eff; j++)
                  if (pat_store[j] != cfg_wild) region_bytes[off + j] = pat_store[j];
            end
            ends = !(r == regions - 1 && $urandom_range(0, 2) == 0);
            for (int b = 0; b < n && word_count < RANDOM_WORDS; b++) begin
               if ($urandom_range(0, 19) == 0)
                  send_word(FUNC_LOAD, 6'($urandom), 8'($urandom), 1'($urandom),
                            CHK_MODEL, NO_RESULT);
               send_word(FUNC_SCAN, 6'($urandom), region_bytes[b], ends && (b == n - 1),
                         CHK_MODEL, NO_RESULT);
            end
         end
         phase++;
      end

      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      wait_idle();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== wildcard_byte_pattern_scan_top.f =====
hdl/wbps_pkg.sv
hdl/wbps_front.sv
hdl/wbps_back.sv
hdl/wildcard_byte_pattern_scan_top.sv
hdl/wbps_checker.sv
tb/tb_wildcard_byte_pattern_scan_top.sv
